@@ rtl/bresenham_line_rasterizer_defines.svh @@
// Assertion macros shared by the rasterizer RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef BRESENHAM_LINE_RASTERIZER_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_DEFINES_SVH

`ifndef SYNTHESIS
`define BLR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define BLR_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BLR_ASSERT(lbl, clk, rstn, prop, msg)
`define BLR_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/blr_pkg.sv @@
// Package for the line rasterizer: widths, function codes, queue entry type.
// No dependencies.
`timescale 1ns / 1ps

package blr_pkg;

    localparam int COORD_BITS = 11;
    localparam int POS_W      = COORD_BITS + 1;
    localparam int INC_W      = COORD_BITS + 3;
    localparam int ERR_W      = COORD_BITS + 4;
    localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD    = OUT_DATA_W - 2 * COORD_BITS;
    localparam int Q_AW       = 1;
    localparam int Q_DEPTH    = 1 << Q_AW;

    typedef enum logic {
        FUNC_START   = 1'b0,
        FUNC_ADVANCE = 1'b1
    } func_t;

    typedef struct packed {
        func_t                   func;
        logic                    steep;
        logic                    mirror;
        logic signed [POS_W-1:0] major;
        logic signed [POS_W-1:0] minor;
        logic signed [POS_W-1:0] major_final;
        logic signed [INC_W-1:0] inc_straight;
        logic signed [INC_W-1:0] inc_diagonal;
        logic signed [ERR_W-1:0] error_init;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_if_t;

endpackage

@@ rtl/blr_front.sv @@
// Front end: accepts input transactions and classifies start items into
// octant flags, ordered endpoints and error setup. Depends on blr_pkg.
`timescale 1ns / 1ps

module blr_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [blr_pkg::IN_DATA_W-1:0]  s_tdata,  // x_start, y_start, x_end, y_end
    input  logic                           s_tuser,  // func
    input  logic                           q_full,
    output blr_pkg::q_if_t                 q_wr
);

    localparam int C = blr_pkg::COORD_BITS;
    localparam int P = blr_pkg::POS_W;

    logic [C-1:0]        x1, y1, x2, y2;
    logic signed [P-1:0] xs1, xs2, ys1, ys2, ym1, ym2;
    logic signed [P-1:0] dx, dy, neg_dx, neg_dy;
    logic [C-1:0]        ax, ay, amaj, amin;
    logic                dx_neg, dx_pos, dy_neg, dy_pos;
    logic                mirror, steep, swap;
    logic signed [P-1:0] maj1, min1, maj2, min2;

    assign x1 = s_tdata[C-1:0];
    assign y1 = s_tdata[2*C-1:C];
    assign x2 = s_tdata[3*C-1:2*C];
    assign y2 = s_tdata[4*C-1:3*C];

    assign xs1 = $signed({1'b0, x1});
    assign xs2 = $signed({1'b0, x2});
    assign ys1 = $signed({1'b0, y1});
    assign ys2 = $signed({1'b0, y2});

    assign dx     = xs2 - xs1;
    assign dy     = ys2 - ys1;
    assign neg_dx = -dx;
    assign neg_dy = -dy;
    assign ax     = dx[P-1] ? neg_dx[C-1:0] : dx[C-1:0];
    assign ay     = dy[P-1] ? neg_dy[C-1:0] : dy[C-1:0];

    assign dx_neg = dx[P-1];
    assign dy_neg = dy[P-1];
    assign dx_pos = !dx[P-1] && (dx != '0);
    assign dy_pos = !dy[P-1] && (dy != '0);
    assign mirror = (dx_neg && dy_pos) || (dx_pos && dy_neg);
    assign steep  = ax < ay;

    assign ym1 = mirror ? -ys1 : ys1;
    assign ym2 = mirror ? -ys2 : ys2;

    assign maj1 = steep ? ym1 : xs1;
    assign min1 = steep ? xs1 : ym1;
    assign maj2 = steep ? ym2 : xs2;
    assign min2 = steep ? xs2 : ym2;
    assign swap = maj1 > maj2;

    assign amaj = steep ? ay : ax;
    assign amin = steep ? ax : ay;

    assign s_tready = !q_full;

    always_comb begin
        q_wr.valid              = s_tvalid && !q_full;
        q_wr.entry.func         = blr_pkg::func_t'(s_tuser);
        q_wr.entry.steep        = steep;
        q_wr.entry.mirror       = mirror;
        q_wr.entry.major        = swap ? maj2 : maj1;
        q_wr.entry.minor        = swap ? min2 : min1;
        q_wr.entry.major_final  = swap ? maj1 : maj2;
        q_wr.entry.inc_straight = $signed({2'b00, amin, 1'b0});
        q_wr.entry.inc_diagonal = $signed({2'b00, amin, 1'b0}) - $signed({2'b00, amaj, 1'b0});
        q_wr.entry.error_init   = $signed({3'b000, amin, 1'b0}) - $signed({4'b0000, amaj});
    end

endmodule

@@ rtl/blr_queue.sv @@
// Short register queue between the front end and the stepping back end.
// Depends on blr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bresenham_line_rasterizer_defines.svh"

module blr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  blr_pkg::q_if_t q_wr,
    output logic           q_full,
    output blr_pkg::q_if_t q_rd,
    input  logic           q_pop
);

    localparam int AW = blr_pkg::Q_AW;
    localparam int D  = blr_pkg::Q_DEPTH;

    blr_pkg::entry_t mem_reg [D];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    logic            do_push, do_pop;

    assign q_full     = count_reg == (AW+1)'(D);
    assign do_push    = q_wr.valid && !q_full;
    assign do_pop     = q_pop && (count_reg != '0);
    assign q_rd.valid = count_reg != '0;
    assign q_rd.entry = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= q_wr.entry;
        end
    end

    `BLR_ASSERT(a_q_count_bound, aclk, aresetn, count_reg <= (AW+1)'(D), "queue count overflow")
    `BLR_ASSERT(a_q_empty_ptrs, aclk, aresetn, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "queue pointers diverge while empty")
    `BLR_ASSERT(a_q_full_hold, aclk, aresetn, (q_full && !q_pop) |=> q_full, "queue lost an entry while full")

endmodule

@@ rtl/blr_back.sv @@
// Back end: Bresenham stepping state and the output register.
// Depends on blr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bresenham_line_rasterizer_defines.svh"

module blr_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  blr_pkg::q_if_t                  q_rd,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [blr_pkg::OUT_DATA_W-1:0]  m_tdata,  // pixel_x, pixel_y
    output logic                            m_tlast   // last_pixel
);

    localparam int C = blr_pkg::COORD_BITS;
    localparam int P = blr_pkg::POS_W;
    localparam int I = blr_pkg::INC_W;
    localparam int E = blr_pkg::ERR_W;

    logic                busy_reg, busy_next;
    logic signed [E-1:0] err_reg, err_next;
    logic signed [P-1:0] major_reg, major_next;
    logic signed [P-1:0] minor_reg, minor_next;
    logic signed [P-1:0] final_reg, final_next;
    logic signed [I-1:0] inc_s_reg, inc_s_next;
    logic signed [I-1:0] inc_d_reg, inc_d_next;
    logic                steep_reg, steep_next;
    logic                mirror_reg, mirror_next;

    logic                m_valid_reg, m_valid_next;
    logic [C-1:0]        px_reg, px_next;
    logic [C-1:0]        py_reg, py_next;
    logic                last_reg, last_next;

    logic                produce, last;
    logic signed [P-1:0] px_raw, py_raw, py_neg;

    assign q_pop = q_rd.valid && (!m_valid_reg || m_tready);

    always_comb begin
        busy_next   = busy_reg;
        err_next    = err_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        final_next  = final_reg;
        inc_s_next  = inc_s_reg;
        inc_d_next  = inc_d_reg;
        steep_next  = steep_reg;
        mirror_next = mirror_reg;
        produce     = 1'b0;
        if (q_pop) begin
            if (q_rd.entry.func == blr_pkg::FUNC_START) begin
                err_next    = q_rd.entry.error_init;
                major_next  = q_rd.entry.major;
                minor_next  = q_rd.entry.minor;
                final_next  = q_rd.entry.major_final;
                inc_s_next  = q_rd.entry.inc_straight;
                inc_d_next  = q_rd.entry.inc_diagonal;
                steep_next  = q_rd.entry.steep;
                mirror_next = q_rd.entry.mirror;
                produce     = 1'b1;
            end else if (busy_reg) begin
                if (err_reg[E-1] || (err_reg == '0)) begin
                    err_next = err_reg + E'(inc_s_reg);
                end else begin
                    err_next   = err_reg + E'(inc_d_reg);
                    minor_next = minor_reg + 1'b1;
                end
                major_next = major_reg + 1'b1;
                produce    = 1'b1;
            end
        end
        last = major_next >= final_next;
        if (produce) begin
            busy_next = !last;
        end
    end

    always_comb begin
        px_raw = steep_next ? minor_next : major_next;
        py_raw = steep_next ? major_next : minor_next;
        py_neg = -py_raw;
        if (produce) begin
            px_next      = px_raw[C-1:0];
            py_next      = mirror_next ? py_neg[C-1:0] : py_raw[C-1:0];
            last_next    = last;
            m_valid_next = 1'b1;
        end else begin
            px_next      = px_reg;
            py_next      = py_reg;
            last_next    = last_reg;
            m_valid_next = m_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg    <= err_next;
        major_reg  <= major_next;
        minor_reg  <= minor_next;
        final_reg  <= final_next;
        inc_s_reg  <= inc_s_next;
        inc_d_reg  <= inc_d_next;
        steep_reg  <= steep_next;
        mirror_reg <= mirror_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{blr_pkg::OUT_PAD{1'b0}}, py_reg, px_reg};
    assign m_tlast  = last_reg;

    `BLR_ASSERT(a_busy_short_of_end, aclk, aresetn, busy_reg |-> (major_reg < final_reg), "busy at or past far end")
    `BLR_ASSERT(a_advance_emits, aclk, aresetn, (q_pop && busy_reg) |=> m_valid_reg, "advance while busy produced no pixel")
    `BLR_ASSERT_RST(a_reset_idle, aclk, !aresetn |=> (!m_valid_reg && !busy_reg), "not idle after reset")

endmodule

@@ rtl/bresenham_line_rasterizer.sv @@
// Top level of the Bresenham line rasterizer: front end, queue, back end.
// Depends on blr_pkg, blr_front, blr_queue and blr_back.
//
// Usage:
//   Input stream (s_): s_tuser is the function, 0 starts a segment and
//   1 advances one pixel. s_tdata carries x_start, y_start, x_end, y_end
//   (11 bits each, from the low bit up); it is read only on a start.
//   Output stream (m_): s_tdata-like m_tdata holds pixel_x then pixel_y,
//   m_tlast marks the pixel that ends the segment.
//   Every start transaction yields one pixel; an advance yields the next
//   pixel while a segment is open and nothing otherwise. A start while a
//   segment is open drops the old segment.
//   A pixel is registered in the queue and then in the output register
//   before it is valid on the output stream.
//   Throughput: one transaction per cycle while the receiver takes each
//   pixel, set by the add and compare of the back end step.
//   A stalled receiver holds the output register; the two-entry queue
//   then fills and s_tready drops until the output drains.
//   Reset (aresetn low, synchronous) empties the queue, clears the output
//   and closes any open segment.
`timescale 1ns / 1ps

module bresenham_line_rasterizer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [blr_pkg::IN_DATA_W-1:0]   s_tdata,  // x_start, y_start, x_end, y_end
    input  logic                            s_tuser,  // func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [blr_pkg::OUT_DATA_W-1:0]  m_tdata,  // pixel_x, pixel_y
    output logic                            m_tlast   // last_pixel
);

    blr_pkg::q_if_t q_wr;
    blr_pkg::q_if_t q_rd;
    logic           q_full;
    logic           q_pop;

    blr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_wr     (q_wr)
    );

    blr_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .q_full  (q_full),
        .q_rd    (q_rd),
        .q_pop   (q_pop)
    );

    blr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rd     (q_rd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
